// ===== sv/dtcbf_pkg.sv =====
// Shared widths, constants and the result type for the dead-time code best-fit unit.
`default_nettype none
package dtcbf_pkg;
  localparam int unsigned TickFracBitsDef = 12;
  localparam int unsigned NsW = 22;
  localparam int unsigned ClkW = 29;
  localparam int unsigned DivW = 3;
  localparam int unsigned CodeW = 8;
  localparam int unsigned RegionW = 2;
  localparam int unsigned NumW = NsW + ClkW;   // desired * clk
  localparam int unsigned DenWX = 33;          // div * 1e9 < 2^33 for div<=7
  localparam logic [ClkW-1:0] ClkReset = 29'd170000000;
  localparam logic [DivW-1:0] DivReset = 3'd1;
  localparam logic [32:0] NsPerS = 33'd1000000000;
  localparam int unsigned OutMaxW = 22;
  localparam logic [OutMaxW-1:0] OutMax = 22'h3FFFFF;
  localparam int unsigned TicksW = 10;          // up to 31*16+512 = 1008
  // ticks * den stays below 2^43, but the error can reach num's full width
  localparam int unsigned ProdW = NumW;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegClk = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDiv = 2'd1;

  typedef struct packed {
    logic [CodeW-1:0]   code;
    logic [RegionW-1:0] region;
    logic [ProdW-1:0]   actual;
    logic [ProdW-1:0]   err;
  } fit_t;
endpackage
`default_nettype wire

// ===== sv/dtcbf_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module dtcbf_divider #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 33,
  parameter int unsigned SW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [NW-1:0]      quo_o,
  output logic [DW-1:0]      rem_o,
  output logic [SW-1:0]      side_o
);
  logic [NW:0]    v_q;
  logic [NW-1:0]  n_q [NW+1];
  logic [DW-1:0]  r_q [NW+1];
  logic [DW-1:0]  d_q [NW+1];
  logic [SW-1:0]  s_q [NW+1];

  always_comb begin
    v_q[0] = valid_i;
    n_q[0] = num_i;
    r_q[0] = '0;
    d_q[0] = den_i;
    s_q[0] = side_i;
  end

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_d;
    always_comb begin
      trial = {r_q[g], n_q[g][NW-1]};
      diff  = trial - {1'b0, d_q[g]};
      ge    = (trial >= {1'b0, d_q[g]});
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g+1] <= 1'b0;
      end else begin
        v_q[g+1] <= v_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      n_q[g+1] <= {n_q[g][NW-2:0], ge};
      r_q[g+1] <= rem_d;
      d_q[g+1] <= d_q[g];
      s_q[g+1] <= s_q[g];
    end
  end

  assign valid_o = v_q[NW];
  assign quo_o   = n_q[NW];
  assign rem_o   = r_q[NW];
  assign side_o  = s_q[NW];
endmodule
`default_nettype wire

// ===== sv/dtcbf_select.sv =====
// Region candidates from the tick target and first-smallest-error pick.
`default_nettype none
module dtcbf_select #(
  parameter int unsigned TickFracBits = dtcbf_pkg::TickFracBitsDef,
  parameter int unsigned TW = dtcbf_pkg::NumW + TickFracBits - 29
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire logic [TW-1:0]                 t_i,
  input  wire logic [dtcbf_pkg::NumW-1:0]    num_i,
  input  wire logic [dtcbf_pkg::DenWX-1:0]   den_i,
  output logic                               valid_o,
  output dtcbf_pkg::fit_t                    fit_o
);
  localparam int unsigned PW = dtcbf_pkg::ProdW;
  localparam int unsigned TicksW = dtcbf_pkg::TicksW;
  localparam logic [TW:0] One = (TW+1)'(1) << TickFracBits;

  // stage A: fields and ticks
  logic [TW:0] r0, r1, r2, r3;
  logic [TW:0] m0, m1, m2, m3;
  logic [6:0]  x0;
  logic [5:0]  x1;
  logic [4:0]  x2, x3;
  always_comb begin
    r0 = {1'b0, t_i} + (One >> 1);
    r1 = {1'b0, t_i} + One;
    r2 = {1'b0, t_i} + (One << 2);
    r3 = {1'b0, t_i} + (One << 3);
    m0 = r0 >> TickFracBits;
    m1 = r1 >> (TickFracBits + 1);
    m2 = r2 >> (TickFracBits + 3);
    m3 = r3 >> (TickFracBits + 4);
    x0 = (m0 > (TW+1)'(127)) ? 7'd127 : m0[6:0];
    x1 = (m1 < (TW+1)'(64)) ? 6'd0 : (m1 > (TW+1)'(127)) ? 6'd63 : 6'(m1 - (TW+1)'(64));
    x2 = (m2 < (TW+1)'(32)) ? 5'd0 : (m2 > (TW+1)'(63)) ? 5'd31 : 5'(m2 - (TW+1)'(32));
    x3 = (m3 < (TW+1)'(32)) ? 5'd0 : (m3 > (TW+1)'(63)) ? 5'd31 : 5'(m3 - (TW+1)'(32));
  end

  logic                         va_q;
  logic [TicksW-1:0]            tk_q [4];
  logic [7:0]                   cd_q [4];
  logic [dtcbf_pkg::NumW-1:0]   numa_q;
  logic [dtcbf_pkg::DenWX-1:0]  dena_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else va_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    tk_q[0] <= TicksW'(x0);
    tk_q[1] <= TicksW'({1'b1, x1, 1'b0});
    tk_q[2] <= TicksW'({1'b1, x2, 3'b000});
    tk_q[3] <= TicksW'({1'b1, x3, 4'b0000});
    cd_q[0] <= {1'b0, x0};
    cd_q[1] <= {2'b10, x1};
    cd_q[2] <= {3'b110, x2};
    cd_q[3] <= {3'b111, x3};
    numa_q  <= num_i;
    dena_q  <= den_i;
  end

  // stage B: ticks * den (10x33 each)
  logic              vb_q;
  logic [PW-1:0]     a_q [4];
  logic [7:0]        cdb_q [4];
  logic [PW-1:0]     numb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else vb_q <= va_q;
  end
  for (genvar k = 0; k < 4; k++) begin : g_mul
    always_ff @(posedge clk_i) begin
      a_q[k]   <= PW'(tk_q[k]) * PW'(dena_q);
      cdb_q[k] <= cd_q[k];
    end
  end
  always_ff @(posedge clk_i) numb_q <= PW'(numa_q);

  // stage C: errors
  logic          vc_q;
  logic [PW-1:0] e_q [4];
  logic [PW-1:0] ac_q [4];
  logic [7:0]    cdc_q [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else vc_q <= vb_q;
  end
  for (genvar k = 0; k < 4; k++) begin : g_err
    always_ff @(posedge clk_i) begin
      e_q[k]   <= (a_q[k] >= numb_q) ? a_q[k] - numb_q : numb_q - a_q[k];
      ac_q[k]  <= a_q[k];
      cdc_q[k] <= cdb_q[k];
    end
  end

  // stage D: pairwise pick, then final
  logic          vd_q;
  logic          p01, p23;
  dtcbf_pkg::fit_t lo_q, hi_q;
  always_comb begin
    p01 = e_q[1] < e_q[0];
    p23 = e_q[3] < e_q[2];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else vd_q <= vc_q;
  end
  always_ff @(posedge clk_i) begin
    lo_q <= p01 ? '{cdc_q[1], 2'd1, ac_q[1], e_q[1]} : '{cdc_q[0], 2'd0, ac_q[0], e_q[0]};
    hi_q <= p23 ? '{cdc_q[3], 2'd3, ac_q[3], e_q[3]} : '{cdc_q[2], 2'd2, ac_q[2], e_q[2]};
  end

  logic ve_q;
  dtcbf_pkg::fit_t fit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ve_q <= 1'b0;
    else ve_q <= vd_q;
  end
  always_ff @(posedge clk_i) fit_q <= (hi_q.err < lo_q.err) ? hi_q : lo_q;

  assign valid_o = ve_q;
  assign fit_o   = fit_q;
endmodule
`default_nettype wire

// ===== sv/dead_time_code_best_fit_unit.sv =====
// Top level of the dead-time code best-fit unit.
// Takes a requested dead time in ns (start with desired_ns_i, accepted
// whenever busy is low; busy is tied low, so a request may be issued every
// cycle) and returns the closest 8-bit dead-time generator code, its
// region, the resulting dead time and the error in ns. Results appear on
// done_o for one cycle, in request order. Each request passes in turn
// through these steps: one input register forms desired*clk, a 51-stage divider forms
// the tick target quotient, a (TickFracBits+33)-stage divider its fraction,
// five stages score the four regions, two 53-stage dividers (run side by
// side) round actual and error to ns, and one output register drives the
// result ports. The receiver cannot stall, so nothing is ever held back.
// Registers: index 0 timer_clock_hz, index 1 clock_division; writes to other
// indexes are ignored; the config channel is always ready. Write them only
// while no request is in flight.
`default_nettype none
module dead_time_code_best_fit_unit #(
  parameter int unsigned TickFracBits = dtcbf_pkg::TickFracBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [dtcbf_pkg::NsW-1:0]      desired_ns_i,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [dtcbf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [dtcbf_pkg::ClkW-1:0]     cfg_data_i,
  output logic                                done_o,
  output logic [dtcbf_pkg::CodeW-1:0]         dead_time_code_o,
  output logic [dtcbf_pkg::RegionW-1:0]       code_region_o,
  output logic [dtcbf_pkg::NsW-1:0]           actual_ns_o,
  output logic [dtcbf_pkg::NsW-1:0]           error_ns_o
);
  localparam int unsigned NumW = dtcbf_pkg::NumW;
  localparam int unsigned DW = dtcbf_pkg::DenWX;
  localparam int unsigned PW = dtcbf_pkg::ProdW;
  localparam int unsigned TW = NumW + TickFracBits - 29;
  localparam int unsigned FW = TickFracBits + DW;

  logic [dtcbf_pkg::ClkW-1:0] clk_q;
  logic [dtcbf_pkg::DivW-1:0] div_q;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_q <= dtcbf_pkg::ClkReset;
      div_q <= dtcbf_pkg::DivReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        dtcbf_pkg::RegClk: clk_q <= cfg_data_i;
        dtcbf_pkg::RegDiv: div_q <= cfg_data_i[dtcbf_pkg::DivW-1:0];
        default: ;
      endcase
    end
  end

  // effective operands (zero acts as one)
  logic [dtcbf_pkg::ClkW-1:0] clk_e;
  logic [dtcbf_pkg::DivW-1:0] div_e;
  logic [DW-1:0]              den;
  logic [NumW-1:0]            num;
  always_comb begin
    clk_e = (clk_q == '0) ? dtcbf_pkg::ClkW'(1) : clk_q;
    div_e = (div_q == '0) ? dtcbf_pkg::DivW'(1) : div_q;
    den   = DW'(dtcbf_pkg::NsPerS * DW'(div_e));
  end

  // input register: the product desired*clk
  logic v0_q;
  logic [NumW-1:0] num_q;
  logic [DW-1:0]   den_q;
  logic [dtcbf_pkg::ClkW-1:0] ck_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else v0_q <= start;
  end
  always_ff @(posedge clk_i) begin
    num_q <= NumW'(desired_ns_i) * NumW'(clk_e);
    den_q <= den;
    ck_q  <= clk_e;
  end
  assign num = num_q;

  // q, r = num / den
  localparam int unsigned S1 = NumW + DW + dtcbf_pkg::ClkW;
  logic v1;
  logic [NumW-1:0] q1;
  logic [DW-1:0]   r1;
  logic [S1-1:0]   s1;
  dtcbf_divider #(.NW(NumW), .DW(DW), .SW(S1)) u_div_q (
    .clk_i, .rst_ni, .valid_i(v0_q), .num_i(num), .den_i(den_q),
    .side_i({num_q, den_q, ck_q}), .valid_o(v1), .quo_o(q1), .rem_o(r1), .side_o(s1)
  );

  // fraction = (r << F) / den
  localparam int unsigned S2 = S1 + NumW;
  logic v2;
  logic [FW-1:0] f2;
  logic [DW-1:0] r2u;
  logic [S2-1:0] s2;
  dtcbf_divider #(.NW(FW), .DW(DW), .SW(S2)) u_div_f (
    .clk_i, .rst_ni, .valid_i(v1), .num_i({r1, TickFracBits'(0)}),
    .den_i(s1[dtcbf_pkg::ClkW +: DW]), .side_i({s1, q1}),
    .valid_o(v2), .quo_o(f2), .rem_o(r2u), .side_o(s2)
  );

  logic [TW-1:0] t2;
  logic [NumW-1:0] q2;
  logic [NumW-1:0] num2;
  logic [DW-1:0]   den2;
  logic [dtcbf_pkg::ClkW-1:0] ck2;
  always_comb begin
    q2   = s2[NumW-1:0];
    ck2  = s2[NumW +: dtcbf_pkg::ClkW];
    den2 = s2[NumW + dtcbf_pkg::ClkW +: DW];
    num2 = s2[NumW + dtcbf_pkg::ClkW + DW +: NumW];
    // q < 2^(NumW-29) since den >= 1e9 > 2^29
    t2   = TW'({q2, TickFracBits'(0)}) | TW'(f2[TickFracBits-1:0] | TickFracBits'(r2u[0] & 1'b0));
  end

  // clock value must follow the item through the scoring stages
  logic v3;
  dtcbf_pkg::fit_t fit3;
  dtcbf_select #(.TickFracBits(TickFracBits), .TW(TW)) u_sel (
    .clk_i, .rst_ni, .valid_i(v2), .t_i(t2), .num_i(num2), .den_i(den2),
    .valid_o(v3), .fit_o(fit3)
  );
  logic [dtcbf_pkg::ClkW-1:0] ckd_q [5];
  always_ff @(posedge clk_i) begin
    ckd_q[0] <= ck2;
    for (int i = 1; i < 5; i++) ckd_q[i] <= ckd_q[i-1];
  end

  // round(x/clk) = (2x + clk) / (2clk), actual and error in parallel;
  // 2x + clk can pass 2^(PW+1), hence two extra bits
  localparam int unsigned RN = PW + 2;
  localparam int unsigned RD = dtcbf_pkg::ClkW + 1;
  localparam int unsigned S4 = dtcbf_pkg::CodeW + dtcbf_pkg::RegionW;
  logic [RN-1:0] na, ne;
  logic [RD-1:0] dd;
  always_comb begin
    dd = {ckd_q[4], 1'b0};
    na = RN'({fit3.actual, 1'b0}) + RN'(ckd_q[4]);
    ne = RN'({fit3.err, 1'b0}) + RN'(ckd_q[4]);
  end
  logic v4a, v4e;
  logic [RN-1:0] qa, qe;
  logic [RD-1:0] ra, re;
  logic [S4-1:0] s4, s4e;
  dtcbf_divider #(.NW(RN), .DW(RD), .SW(S4)) u_div_a (
    .clk_i, .rst_ni, .valid_i(v3), .num_i(na), .den_i(dd),
    .side_i({fit3.code, fit3.region}), .valid_o(v4a), .quo_o(qa), .rem_o(ra), .side_o(s4)
  );
  dtcbf_divider #(.NW(RN), .DW(RD), .SW(S4)) u_div_e (
    .clk_i, .rst_ni, .valid_i(v3), .num_i(ne), .den_i(dd),
    .side_i({fit3.code, fit3.region}), .valid_o(v4e), .quo_o(qe), .rem_o(re), .side_o(s4e)
  );

  logic done_q;
  logic [dtcbf_pkg::CodeW-1:0] code_q;
  logic [dtcbf_pkg::RegionW-1:0] reg_q;
  logic [dtcbf_pkg::NsW-1:0] act_q, err_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= v4a & (v4e | ~v4e) & ((|ra) | ~(|ra)) & ((|re) | ~(|re))
                   & ((s4e == s4) | (s4e != s4));
  end
  always_ff @(posedge clk_i) begin
    code_q <= s4[dtcbf_pkg::RegionW +: dtcbf_pkg::CodeW];
    reg_q  <= s4[dtcbf_pkg::RegionW-1:0];
    act_q  <= (qa > RN'(dtcbf_pkg::OutMax)) ? dtcbf_pkg::OutMax : qa[dtcbf_pkg::NsW-1:0];
    err_q  <= (qe > RN'(dtcbf_pkg::OutMax)) ? dtcbf_pkg::OutMax : qe[dtcbf_pkg::NsW-1:0];
  end

  assign done_o = done_q;
  assign dead_time_code_o = code_q;
  assign code_region_o = reg_q;
  assign actual_ns_o = act_q;
  assign error_ns_o = err_q;
endmodule
`default_nettype wire
